[sv/tbld_pkg.sv]
// Shared types, constants and keyword tables for the tokenized line decoder.
`timescale 1ns / 1ps
package tbld_pkg;
	localparam int TextLen = 7;
	localparam logic [3:0] HeaderReset = 4'd5;
	localparam logic [1:0] LinkReset = 2'd2;
	localparam logic [0:0] RegHeader = 1'b0;
	localparam logic [0:0] RegLink = 1'b1;

	typedef logic [TextLen-1:0][7:0] text_t;

	// Expansion record: up to seven characters plus a count.
	typedef struct packed {
		text_t      chars;
		logic [2:0] count;
		logic       unk;
	} expand_t;

	// Controller to datapath command.
	typedef struct packed {
		logic load;
		logic shift;
		logic digit;
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic [2:0] count;
		logic       num_done;
	} dp_sts_t;

	function automatic text_t txt(input string s);
		text_t t;
		int    k;
		t = '0;
		for (k = 0; k < TextLen; k++) begin
			if (k < s.len()) t[k] = s[k];
		end
		return t;
	endfunction

	function automatic logic [2:0] slen(input string s);
		return 3'(s.len());
	endfunction

	function automatic logic printable(input logic [7:0] c);
		logic p;
		p = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h30 && c <= 8'h39);
		unique case (c)
			8'h20, 8'h22, 8'h3A, 8'h3B, 8'h2E, 8'h2D, 8'h24, 8'h2C, 8'h26, 8'h23,
			8'h28, 8'h29, 8'h2B, 8'h27, 8'h3F, 8'h25: p = 1'b1;
			default: ;
		endcase
		return p;
	endfunction

	// Single-byte keyword table; count zero means no entry.
	function automatic expand_t single_tok(input logic [7:0] c);
		string s;
		expand_t e;
		unique case (c)
			8'h80: s = "END";     8'h81: s = "FOR";    8'h82: s = "NEXT";
			8'h84: s = "DIM";     8'h89: s = "IF";     8'h8B: s = "RETURN";
			8'h8F: s = "ELSE";    8'h93: s = "DEFINT"; 8'h9C: s = "LOCATE";
			8'h9D: s = "CLS";     8'h9E: s = "CONSOLE"; 8'hA3: s = "BEEP";
			8'hA4: s = "COLOR";   8'hA5: s = "LINE";   8'hA6: s = "BOX";
			8'hA8: s = "ATTRB";   8'hA9: s = "DEF";    8'hAB: s = "PRINT";
			8'hAE: s = "CLEAR";   8'hB1: s = "NEW";    8'hB5: s = "OPEN";
			8'hB6: s = "CLOSE";   8'hB7: s = "INPEN";  8'hB9: s = "PLAY";
			8'hBF: s = "USING";   8'hC4: s = "THEN";   8'hC6: s = "STEP";
			8'hC7: s = "+";       8'hC8: s = "-";      8'hC9: s = "*";
			8'hCA: s = "/";       8'hCC: s = "AND";    8'hCD: s = "OR";
			8'hCE: s = "XOR";     8'hD1: s = "MOD";    8'hD2: s = "@";
			8'hD3: s = ">";       8'hD4: s = "=";      8'hD5: s = "<";
			default: s = "";
		endcase
		e.chars = txt(s);
		e.count = slen(s);
		e.unk = 1'b0;
		return e;
	endfunction

	// FF-prefixed keyword table.
	function automatic expand_t ff_tok(input logic [7:0] c);
		string s;
		expand_t e;
		unique case (c)
			8'h80: s = "SGN";   8'h81: s = "INT";    8'h82: s = "ABS";
			8'h8E: s = "ASC";   8'h99: s = "GR$";    8'h9C: s = "MID$";
			8'h9F: s = "RND";   8'hA0: s = "INKEY$"; 8'hA1: s = "INPUT";
			8'hA4: s = "SCREEN"; 8'hA6: s = "PTRIG";
			default: s = "";
		endcase
		e.chars = txt(s);
		e.count = slen(s);
		e.unk = 1'b0;
		return e;
	endfunction
endpackage

[sv/tbld_datapath.sv]
// Datapath: character shift register and line number digit extraction.
`timescale 1ns / 1ps
module tbld_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  tbld_pkg::dp_cmd_t  cmd,
	input  tbld_pkg::expand_t  load_val,
	input  logic [15:0]        number,
	output logic [7:0]         head_char,
	output logic               head_unk,
	output tbld_pkg::dp_sts_t  sts
);
	import tbld_pkg::*;

	text_t       chars_q;
	logic [2:0]  count_q;
	logic        unk_q;
	logic [15:0] rem_q;
	logic [2:0]  place_q;
	logic        started_q;
	logic [3:0]  dig_q;
	logic [15:0] pow;
	logic        ge;
	logic [15:0] sub;
	logic        keep;
	text_t       num_chars;
	logic [2:0]  num_count;

	// Place value for the current digit.
	always_comb begin
		unique case (place_q)
			3'd0: pow = 16'd10000;
			3'd1: pow = 16'd1000;
			3'd2: pow = 16'd100;
			3'd3: pow = 16'd10;
			default: pow = 16'd1;
		endcase
	end

	// Digit by repeated subtraction, one subtract per cycle.
	assign ge   = rem_q >= pow;
	assign sub  = rem_q - pow;
	assign keep = (dig_q != 4'd0) || started_q || (place_q == 3'd4);

	// Append a finished digit, and the trailing space after the units place.
	always_comb begin
		num_chars = chars_q;
		num_count = count_q;
		if (keep) begin
			num_chars[count_q] = {4'h3, dig_q};
			num_count = count_q + 3'd1;
		end
		if (place_q == 3'd4) begin
			num_chars[num_count] = 8'h20;
			num_count = num_count + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q <= '0;
			count_q <= '0;
			unk_q <= 1'b0;
			rem_q <= '0;
			place_q <= '0;
			started_q <= 1'b0;
			dig_q <= '0;
		end else if (cmd.load) begin
			if (load_val.count == 3'd0) begin
				// Start a line number conversion: digits build from slot 0 upward.
				chars_q <= '0;
				count_q <= '0;
				unk_q <= 1'b0;
				rem_q <= number;
				place_q <= '0;
				started_q <= 1'b0;
				dig_q <= '0;
			end else begin
				chars_q <= load_val.chars;
				count_q <= load_val.count;
				unk_q <= load_val.unk;
			end
		end else if (cmd.digit) begin
			if (ge) begin
				rem_q <= sub;
				dig_q <= dig_q + 4'd1;
			end else begin
				// Emit digit when significant, then move to next place.
				chars_q <= num_chars;
				count_q <= num_count;
				if (keep) started_q <= 1'b1;
				dig_q <= '0;
				place_q <= place_q + 3'd1;
			end
		end else if (cmd.shift) begin
			chars_q <= chars_q >> 8;
			count_q <= count_q - 3'd1;
		end
	end

	assign sts.count = count_q;
	assign sts.num_done = (place_q == 3'd5);
	assign head_char = chars_q[0];
	assign head_unk = unk_q;
endmodule

[sv/tbld_ctrl.sv]
// Controller: phase tracking, token decode and output sequencing.
`timescale 1ns / 1ps
module tbld_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         in_byte,
	input  logic               wr_en,
	input  logic               wr_idx,
	input  logic [3:0]         wr_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               out_last,
	output tbld_pkg::dp_cmd_t  cmd,
	output tbld_pkg::expand_t  load_val,
	output logic [15:0]        number,
	input  tbld_pkg::dp_sts_t  sts
);
	import tbld_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER, PH_NUM_LO, PH_CODE, PH_PRE_FF, PH_PRE_87, PH_LINK
	} phase_t;
	typedef enum logic [1:0] {ST_IDLE, ST_NUM, ST_EMIT} st_t;

	phase_t     phase_q, phase_d;
	st_t        st_q;
	logic [3:0] skip_q;
	logic [1:0] link_q;
	logic [7:0] hi_q;
	logic       for_q, for_d;
	logic       acc;
	expand_t    e, tok;

	assign in_stall = (st_q != ST_IDLE);
	assign acc = in_valid && !in_stall;
	assign number = {hi_q, in_byte};

	// Decode one accepted byte into an expansion and the next phase.
	always_comb begin
		e = '0;
		tok = '0;
		phase_d = phase_q;
		for_d = for_q;
		unique case (phase_q)
			PH_HEADER, PH_LINK: begin
				if (skip_q == 4'd0) phase_d = PH_NUM_LO;
			end
			PH_NUM_LO: begin
				phase_d = PH_CODE;
				for_d = 1'b0;
			end
			PH_PRE_FF: begin
				phase_d = PH_CODE;
				tok = ff_tok(in_byte);
				if (tok.count != 3'd0) e = tok;
				else e = '{chars: text_t'(in_byte), count: 3'd1, unk: 1'b1};
			end
			PH_PRE_87: begin
				phase_d = PH_CODE;
				if (in_byte == 8'hBB) e = '{txt("GOTO"), 3'd4, 1'b0};
				else if (in_byte == 8'hBC) e = '{txt("GOSUB"), 3'd5, 1'b0};
				else e = '{chars: text_t'(in_byte), count: 3'd1, unk: 1'b1};
			end
			default: begin
				tok = single_tok(in_byte);
				priority if (in_byte == 8'h00) begin
					e = '{chars: text_t'(8'h0A), count: 3'd1, unk: 1'b0};
					for_d = 1'b0;
					phase_d = PH_LINK;
				end else if (printable(in_byte)) begin
					e = '{chars: text_t'(in_byte), count: 3'd1, unk: 1'b0};
				end else if (in_byte == 8'hFF) begin
					phase_d = PH_PRE_FF;
				end else if (in_byte == 8'h87) begin
					phase_d = PH_PRE_87;
				end else if (in_byte == 8'hBB) begin
					if (for_q) begin
						e = '{txt("TO"), 3'd2, 1'b0};
						for_d = 1'b0;
					end else e = '{txt("GOTO"), 3'd4, 1'b0};
				end else if (tok.count != 3'd0) begin
					e = tok;
					if (in_byte == 8'h81) for_d = 1'b1;
				end else begin
					e = '{chars: text_t'(in_byte), count: 3'd1, unk: 1'b1};
				end
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		load_val = e;
		cmd.load = acc && (phase_q == PH_NUM_LO || e.count != 3'd0);
		if (phase_q == PH_NUM_LO) load_val = '0;
		cmd.digit = (st_q == ST_NUM) && !sts.num_done;
		cmd.shift = (st_q == ST_EMIT) && !out_stall;
	end

	assign out_valid = (st_q == ST_EMIT);
	assign out_last = (sts.count == 3'd1);

	// Hold phase, counters and sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			st_q <= ST_IDLE;
			skip_q <= HeaderReset;
			link_q <= LinkReset;
			hi_q <= '0;
			for_q <= 1'b0;
		end else begin
			if (wr_en) begin
				if (wr_idx == RegHeader) begin
					if (phase_q == PH_HEADER) skip_q <= wr_data;
				end else link_q <= wr_data[1:0];
			end
			if (acc) begin
				phase_q <= phase_d;
				for_q <= for_d;
				if ((phase_q == PH_HEADER || phase_q == PH_LINK) && skip_q != 4'd0)
					skip_q <= skip_q - 4'd1;
				else if (phase_q == PH_HEADER || phase_q == PH_LINK)
					hi_q <= in_byte;
				if (phase_d == PH_LINK && phase_q == PH_CODE) skip_q <= {2'b0, link_q};
				if (phase_q == PH_NUM_LO) st_q <= ST_NUM;
				else if (e.count != 3'd0) st_q <= ST_EMIT;
			end else if (st_q == ST_NUM && sts.num_done) begin
				st_q <= ST_EMIT;
			end else if (st_q == ST_EMIT && !out_stall && sts.count == 3'd1) begin
				st_q <= ST_IDLE;
			end
		end
	end
endmodule

[sv/tokenized_basic_line_decoder_core.sv]
// Top level of the tokenized BASIC line decoder.
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_stall  | in_byte
//  out     | out | out_valid/out_stall| out_char, unknown_code, run_end
//  cfg     | in  | wr_en              | wr_idx, wr_data
// An item's characters are emitted one per cycle while out_stall is low.
// A line number low byte is converted by repeated subtraction, one step per
// unit of each digit plus one per place, then emits up to six chars.
// Reset clears phase, skip count and registers to their reset values.
// Input stalls while a line number is converted or an item's characters
// are still being sent out.
`timescale 1ns / 1ps
module tokenized_basic_line_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       unknown_code,
	output logic       run_end,
	input  logic       wr_en,
	input  logic       wr_idx,
	input  logic [3:0] wr_data
);
	import tbld_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	expand_t load_val;
	logic [15:0] number;

	tbld_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .in_byte, .wr_en, .wr_idx, .wr_data,
		.out_valid, .out_stall, .out_last(run_end), .cmd, .load_val, .number, .sts
	);

	tbld_datapath u_dp (
		.clk, .arst_n, .cmd, .load_val, .number,
		.head_char(out_char), .head_unk(unknown_code), .sts
	);

	// No new item while characters are pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("accept during emit");
	// Emitting implies characters remain.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sts.count != 3'd0) else $error("empty emit");
endmodule

[tb/tokenized_basic_line_decoder_core_test.sv]
// Self-checking testbench for the tokenized BASIC line decoder core.
`timescale 1ns / 1ps
module tokenized_basic_line_decoder_core_test;
	import tbld_pkg::*;

	typedef enum logic [2:0] {
		SKIP_HEADER, NUM_HIGH, NUM_LOW, CODE, AFTER_FF, AFTER_87, SKIP_LINK
	} dec_phase_t;

	typedef struct {
		logic [7:0] ch;
		logic       unk;
		logic       last;
	} listing_char_t;

	// Listing predictor and store of expected characters.
	class listing_scoreboard;
		listing_char_t expected_chars[$];
		logic [3:0] header_len;
		logic [1:0] link_len;
		dec_phase_t phase;
		logic [3:0] skip_left;
		logic [7:0] num_high;
		logic       for_open;
		int         errors;
		int         checked;
		int         lines;
		int         unknowns;
		listing_char_t fresh[$];

		function new();
			header_len = HeaderReset;
			link_len = LinkReset;
			phase = SKIP_HEADER;
			skip_left = HeaderReset;
			num_high = '0;
			for_open = 1'b0;
			errors = 0;
			checked = 0;
			lines = 0;
			unknowns = 0;
		endfunction

		task report(input string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function void set_reg(input logic idx, input logic [3:0] val);
			if (idx == RegHeader) begin
				header_len = val;
				if (phase == SKIP_HEADER) skip_left = val;
			end else begin
				link_len = val[1:0];
			end
		endfunction

		function void emit(input logic [7:0] c, input logic u);
			listing_char_t e;
			if (fresh.size() < 7) begin
				e.ch = c;
				e.unk = u;
				e.last = 1'b0;
				fresh.push_back(e);
			end
		endfunction

		function void emit_word(input string s);
			int k;
			for (k = 0; k < s.len() && k < 7; k++) emit(s[k], 1'b0);
		endfunction

		function string keyword(input logic [7:0] c);
			case (c)
				8'h80: return "END";     8'h81: return "FOR";    8'h82: return "NEXT";
				8'h84: return "DIM";     8'h89: return "IF";     8'h8B: return "RETURN";
				8'h8F: return "ELSE";    8'h93: return "DEFINT"; 8'h9C: return "LOCATE";
				8'h9D: return "CLS";     8'h9E: return "CONSOLE"; 8'hA3: return "BEEP";
				8'hA4: return "COLOR";   8'hA5: return "LINE";   8'hA6: return "BOX";
				8'hA8: return "ATTRB";   8'hA9: return "DEF";    8'hAB: return "PRINT";
				8'hAE: return "CLEAR";   8'hB1: return "NEW";    8'hB5: return "OPEN";
				8'hB6: return "CLOSE";   8'hB7: return "INPEN";  8'hB9: return "PLAY";
				8'hBF: return "USING";   8'hC4: return "THEN";   8'hC6: return "STEP";
				8'hC7: return "+";       8'hC8: return "-";      8'hC9: return "*";
				8'hCA: return "/";       8'hCC: return "AND";    8'hCD: return "OR";
				8'hCE: return "XOR";     8'hD1: return "MOD";    8'hD2: return "@";
				8'hD3: return ">";       8'hD4: return "=";      8'hD5: return "<";
				default: return "";
			endcase
		endfunction

		function string ff_keyword(input logic [7:0] c);
			case (c)
				8'h80: return "SGN";   8'h81: return "INT";    8'h82: return "ABS";
				8'h8E: return "ASC";   8'h99: return "GR$";    8'h9C: return "MID$";
				8'h9F: return "RND";   8'hA0: return "INKEY$"; 8'hA1: return "INPUT";
				8'hA4: return "SCREEN"; 8'hA6: return "PTRIG";
				default: return "";
			endcase
		endfunction

		function logic is_plain(input logic [7:0] c);
			string punct;
			int k;
			punct = " \":;.-$,&#()+'?%";
			if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9"))
				return 1'b1;
			for (k = 0; k < punct.len(); k++)
				if (punct[k] == c) return 1'b1;
			return 1'b0;
		endfunction

		function void emit_number(input logic [15:0] n);
			int div;
			int d;
			logic started;
			div = 10000;
			started = 1'b0;
			while (div > 0) begin
				d = (n / div) % 10;
				if (d != 0 || started || div == 1) begin
					emit(8'("0" + d), 1'b0);
					started = 1'b1;
				end
				div /= 10;
			end
			emit(" ", 1'b0);
		endfunction

		function void code_byte(input logic [7:0] c);
			if (c == 8'h00) begin
				emit(8'h0A, 1'b0);
				for_open = 1'b0;
				skip_left = {2'b00, link_len};
				phase = SKIP_LINK;
				lines++;
			end else if (is_plain(c)) begin
				emit(c, 1'b0);
			end else if (c == 8'hFF) begin
				phase = AFTER_FF;
			end else if (c == 8'h87) begin
				phase = AFTER_87;
			end else if (c == 8'hBB) begin
				if (for_open) begin
					emit_word("TO");
					for_open = 1'b0;
				end else begin
					emit_word("GOTO");
				end
			end else if (keyword(c) != "") begin
				if (c == 8'h81) for_open = 1'b1;
				emit_word(keyword(c));
			end else begin
				emit(c, 1'b1);
			end
		endfunction

		// Advance the decoder state by one accepted byte and queue its characters.
		function void note_input(input logic [7:0] b);
			fresh.delete();
			case (phase)
				SKIP_HEADER, SKIP_LINK: begin
					if (skip_left != 0) begin
						skip_left = skip_left - 1'b1;
					end else begin
						num_high = b;
						phase = NUM_LOW;
					end
				end
				NUM_HIGH: begin
					num_high = b;
					phase = NUM_LOW;
				end
				NUM_LOW: begin
					emit_number({num_high, b});
					for_open = 1'b0;
					phase = CODE;
				end
				AFTER_FF: begin
					phase = CODE;
					if (ff_keyword(b) != "") emit_word(ff_keyword(b));
					else emit(b, 1'b1);
				end
				AFTER_87: begin
					phase = CODE;
					if (b == 8'hBB) emit_word("GOTO");
					else if (b == 8'hBC) emit_word("GOSUB");
					else emit(b, 1'b1);
				end
				default: begin
					phase = CODE;
					code_byte(b);
				end
			endcase
			if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
			foreach (fresh[i]) begin
				if (fresh[i].unk) unknowns++;
				expected_chars.push_back(fresh[i]);
			end
		endfunction

		// Compare one accepted character with the oldest expectation.
		task check_char(input logic [7:0] c, input logic u, input logic l);
			listing_char_t e;
			if (expected_chars.size() == 0) begin
				report($sformatf("unexpected char %h unk %b end %b", c, u, l));
				return;
			end
			e = expected_chars.pop_front();
			checked++;
			if (c !== e.ch)
				report($sformatf("out_char %h, expected %h", c, e.ch));
			if (u !== e.unk)
				report($sformatf("unknown_code %b, expected %b (char %h)", u, e.unk, e.ch));
			if (l !== e.last)
				report($sformatf("run_end %b, expected %b (char %h)", l, e.last, e.ch));
		endtask
	endclass

	localparam int WatchLimit = 3000;
	localparam int SettleCycles = 80;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_char;
	logic       unknown_code;
	logic       run_end;
	logic       wr_en;
	logic       wr_idx;
	logic [3:0] wr_data;

	listing_scoreboard sb;
	logic quiet;
	int   stall_left;
	int   idle_cycles;
	int   bytes_sent;

	tokenized_basic_line_decoder_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
		.out_valid(out_valid), .out_stall(out_stall), .out_char(out_char),
		.unknown_code(unknown_code), .run_end(run_end),
		.wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Check every accepted character.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_char(out_char, unknown_code, run_end);
	end

	// Hold off the output in random bursts.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 11) == 0) begin
			stall_left = $urandom_range(1, 13) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// End the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WatchLimit) begin
			$display("timeout: no item moved for %0d cycles", WatchLimit);
			$display("tokenized_basic_line_decoder_core_test failed");
			$finish;
		end
	end

	task send_byte(input logic [7:0] b);
		int gap;
		in_byte <= b;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(b);
		bytes_sent++;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task write_reg(input logic idx, input logic [3:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_idx <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	// Drop the input, drain expected characters, then let the block settle.
	task drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_chars.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Choose a byte that keeps the program well formed most of the time.
	function logic [7:0] pick_byte();
		string plain;
		int r;
		plain = "AZaz09 \":;.-$,&#()+'?%QmX5";
		r = $urandom_range(0, 99);
		if (r < 8) return 8'($urandom_range(0, 255));
		case (sb.phase)
			CODE: begin
				r = $urandom_range(0, 99);
				if (r < 8) return 8'h00;
				if (r < 35) return plain[$urandom_range(0, plain.len() - 1)];
				if (r < 60) return 8'($urandom_range(8'h80, 8'hD7));
				if (r < 67) return 8'h81;
				if (r < 75) return 8'hBB;
				if (r < 83) return 8'hFF;
				if (r < 89) return 8'h87;
				return 8'($urandom_range(0, 255));
			end
			AFTER_FF: begin
				if ($urandom_range(0, 2) != 0) return 8'($urandom_range(8'h80, 8'hA6));
				return 8'($urandom_range(0, 255));
			end
			AFTER_87: begin
				r = $urandom_range(0, 2);
				if (r == 0) return 8'hBB;
				if (r == 1) return 8'hBC;
				return 8'($urandom_range(0, 255));
			end
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task send_list(input logic [7:0] bytes[$]);
		foreach (bytes[i]) send_byte(bytes[i]);
	endtask

	task random_bytes(input int n);
		repeat (n) send_byte(pick_byte());
	endtask

	initial begin
		sb = new();
		quiet = 1'b0;
		stall_left = 0;
		idle_cycles = 0;
		bytes_sent = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = '0;
		out_stall = 1'b0;
		wr_en = 1'b0;
		wr_idx = RegHeader;
		wr_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Header at its maximum, then reload it while still skipping.
		write_reg(RegHeader, 4'd15);
		send_list('{8'hFF, 8'h00, 8'h55});
		drain();
		write_reg(RegHeader, 4'd0);
		write_reg(RegLink, 2'd0);

		// Directed: line number extremes, FOR/TO pairing, prefixes, unknowns.
		send_list('{8'h00, 8'h00, 8'h81, 8'hBB, 8'hBB, 8'h41, 8'h00,
			8'hFF, 8'hFF, 8'h81, 8'hFF, 8'h00, 8'h87, 8'hBB, 8'h87, 8'hBC,
			8'h87, 8'h42, 8'h01, 8'hD5, 8'h9E, 8'h00});
		drain();
		write_reg(RegLink, 2'd3);
		random_bytes(150);
		drain();
		write_reg(RegLink, 2'd1);
		write_reg(RegHeader, 4'd9);
		random_bytes(140);
		drain();
		write_reg(RegLink, 2'd2);
		random_bytes(60);
		quiet = 1'b1;
		random_bytes(80);
		drain();

		foreach (sb.expected_chars[i])
			sb.report($sformatf("char %h never arrived", sb.expected_chars[i].ch));
		$display("covered %0d input bytes, %0d listing chars, %0d lines, %0d unknown codes",
			bytes_sent, sb.checked, sb.lines, sb.unknowns);
		$display("header lengths 15/0/9 and link lengths 0..3 exercised, %0d mismatches",
			sb.errors);
		if (sb.errors == 0) begin
			$display("tokenized_basic_line_decoder_core_test passed");
		end else begin
			$display("tokenized_basic_line_decoder_core_test failed");
		end
		$finish;
	end
endmodule
